// File: rtl/core/b2a_pkg.sv
// ----------------------------------------------------------------------------
// b2a_pkg
// Shared widths, codes, hand-off type and digit-to-ASCII mapping for the
// binary to ASCII decimal/hex formatter.
// ----------------------------------------------------------------------------
package b2a_pkg;

   localparam int VALUE_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int DEC_DIGITS = 10;
   localparam int HEX_DIGITS = 8;
   localparam int BCD_W      = DEC_DIGITS * DIGIT_W;
   localparam int CHAR_W     = 7;
   localparam int REM_W      = 4;
   localparam int BITCNT_W   = 5;

   localparam logic OP_DEC = 1'b0;
   localparam logic OP_HEX = 1'b1;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;   // '0'
   localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;   // 'A'

   // converter -> emitter hand-off
   typedef struct packed {
      logic               done;
      logic [BCD_W-1:0]   digits;   // most significant digit at the top
      logic [REM_W-1:0]   ndig;
   } conv_out_type;

   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = {3'b000, d};
      if (d < 4'hA) begin
         return ext + CHAR_ZERO;
      end
      return ext + (CHAR_A - 7'd10);
   endfunction

endpackage

// File: rtl/core/binary_to_ascii_dec_hex.sv
// ----------------------------------------------------------------------------
// binary_to_ascii_dec_hex
// Formats an unsigned 32-bit value as ASCII decimal or upper-case hex digits,
// most significant first, no leading zeros, last flag on the final character.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/stall    | req_value[31:0], req_opcode
//   rsp     | out | rsp_valid/stall    | rsp_digit_char[6:0], rsp_last
//
// Decimal: 32 shift-and-add-3 steps, a hand-off state, then one step per digit
// position (10). Hex: a hand-off state plus 8 digit positions.
// req_stall is high from accept until the last character is in the output
// register; rsp_stall holds the emitter. Reset clears control state only.
// ----------------------------------------------------------------------------
module binary_to_ascii_dec_hex
   import b2a_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_opcode,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_digit_char,
   output logic               rsp_last
);

   logic         conv_busy;
   logic         emit_busy;
   logic         start;
   conv_out_type conv_out;

   assign req_stall = conv_busy || emit_busy;
   assign start     = req_valid && !req_stall;

   b2a_conv u_conv (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .value    (req_value),
      .opcode   (req_opcode),
      .busy     (conv_busy),
      .conv_out (conv_out)
   );

   b2a_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .conv_out       (conv_out),
      .busy           (emit_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   // an accepted beat keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> conv_busy)
      else $error("converter not busy after accept");

   // converter and emitter never work at the same time
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(conv_busy && emit_busy))
      else $error("converter and emitter both busy");

   // every character shown is a legal digit
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_digit_char >= CHAR_ZERO && rsp_digit_char <= 7'h39) ||
                     (rsp_digit_char >= CHAR_A && rsp_digit_char <= 7'h46)))
      else $error("illegal digit character");

   // hand-off only reaches an idle emitter
   a_handoff_idle: assert property (@(posedge clock) disable iff (reset)
      conv_out.done |-> !emit_busy)
      else $error("hand-off while emitter busy");

endmodule

// File: rtl/core/b2a_conv.sv
// ----------------------------------------------------------------------------
// b2a_conv
// Iterative converter: one shift-and-add-3 step per cycle, 32 steps for
// decimal, direct nibble load for hex. Hands the digit word to the emitter.
// ----------------------------------------------------------------------------
module b2a_conv
   import b2a_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [VALUE_W-1:0]  value,
   input  logic                opcode,
   output logic                busy,
   output conv_out_type        conv_out
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [VALUE_W-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic [BITCNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]    ndig_ff, ndig_in;
   logic [BCD_W-1:0]    adj;

   // add-3 correction on every BCD digit ahead of the shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      ndig_in  = ndig_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cnt_in = '0;
               if (opcode == OP_HEX) begin
                  bcd_in   = {value, {(BCD_W-VALUE_W){1'b0}}};
                  ndig_in  = REM_W'(HEX_DIGITS);
                  state_in = ST_DONE;
               end else begin
                  bin_in   = value;
                  bcd_in   = '0;
                  ndig_in  = REM_W'(DEC_DIGITS);
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
            bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == BITCNT_W'(VALUE_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      ndig_ff <= ndig_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign conv_out.done   = (state_ff == ST_DONE);
   assign conv_out.digits = bcd_ff;
   assign conv_out.ndig   = ndig_ff;

endmodule

// File: rtl/core/b2a_emit.sv
// ----------------------------------------------------------------------------
// b2a_emit
// Digit emitter: walks the digit word one nibble a cycle from the top unless
// stalled, drops leading zeros, loads each character into the output register.
// ----------------------------------------------------------------------------
module b2a_emit
   import b2a_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  conv_out_type       conv_out,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_digit_char,
   output logic               rsp_last
);

   logic               busy_ff, busy_in;
   logic               lead_ff, lead_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [BCD_W-1:0]   dig_ff, dig_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;

   logic [DIGIT_W-1:0] nib;
   logic               final_dig;
   logic               step;
   logic               skip;

   assign nib       = dig_ff[BCD_W-1 -: DIGIT_W];
   assign final_dig = (rem_ff == REM_W'(1));
   // advance only when the output register is free or being drained
   assign step      = busy_ff && (!valid_ff || !rsp_stall);
   assign skip      = lead_ff && (nib == '0) && !final_dig;

   always_comb begin
      busy_in  = busy_ff;
      lead_in  = lead_ff;
      rem_in   = rem_ff;
      dig_in   = dig_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (conv_out.done) begin
         busy_in = 1'b1;
         lead_in = 1'b1;
         rem_in  = conv_out.ndig;
         dig_in  = conv_out.digits;
      end else if (step) begin
         dig_in = {dig_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         rem_in = rem_ff - 1'b1;
         if (final_dig) begin
            busy_in = 1'b0;
         end
         if (!skip) begin
            lead_in  = 1'b0;
            valid_in = 1'b1;
            char_in  = digit_ascii(nib);
            last_in  = final_dig;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      lead_ff <= lead_in;
      rem_ff  <= rem_in;
      dig_ff  <= dig_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy           = busy_ff;
   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last       = last_ff;

endmodule
